>>> rtl/necir_pkg.sv
// Shared types, constants and match function for the NEC infrared frame decoder.
package necir_pkg;

    localparam int MAX_SYMBOLS    = 64;
    localparam int COUNT_LIMIT    = ((MAX_SYMBOLS - 1) < 63) ? (MAX_SYMBOLS - 1) : 63;
    localparam int FRAME_SYMBOLS  = 34;
    localparam int REPEAT_SYMBOLS = 2;
    localparam int DATA_SYMBOLS   = 32;

    localparam int TICK_W    = 15;
    localparam int CFG_IDX_W = 3;
    localparam int CNT_W     = 6;
    localparam int WORD_W    = 32;
    localparam int BIT_IDX_W = 5;

    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = 2;
    localparam int OQ_DEPTH = 2;
    localparam int OQ_PTR_W = 1;

    typedef logic [TICK_W-1:0] t_ticks;

    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_MARK    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_SPACE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_MARK  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_SPACE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_MARK     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE    = 3'd7;

    localparam t_ticks RST_TOLERANCE    = 15'd200;
    localparam t_ticks RST_LEAD_MARK    = 15'd9000;
    localparam t_ticks RST_LEAD_SPACE   = 15'd4500;
    localparam t_ticks RST_REPEAT_MARK  = 15'd9000;
    localparam t_ticks RST_REPEAT_SPACE = 15'd2250;
    localparam t_ticks RST_BIT_MARK     = 15'd560;
    localparam t_ticks RST_ZERO_SPACE   = 15'd560;
    localparam t_ticks RST_ONE_SPACE    = 15'd1690;

    typedef enum logic [2:0] {
        ST_FRAME_OK   = 3'd0,
        ST_REPEAT     = 3'd1,
        ST_BAD_LEADER = 3'd2,
        ST_BAD_DATA   = 3'd3,
        ST_BAD_LENGTH = 3'd4
    } t_status;

    typedef struct packed {
        t_ticks mark_ticks;
        t_ticks space_ticks;
        logic   last;
    } t_sym;

    typedef struct packed {
        t_status             status;
        logic [WORD_W-1:0]   frame_word;
        logic [CNT_W-1:0]    bad_index;
    } t_res;

    // Classification of one symbol against every nominal duration.
    typedef struct packed {
        logic leader_ok;
        logic repeat_ok;
        logic bit_one;
        logic bit_zero;
        logic last;
    } t_cls;

    // The lower bound wraps when the tolerance exceeds the nominal value, so nothing matches.
    function automatic logic near_value(t_ticks d, t_ticks nom, t_ticks tol);
        logic [TICK_W:0] hi;
        t_ticks          lo;
        hi = {1'b0, nom} + {1'b0, tol};
        lo = nom - tol;
        return (tol <= nom) && (d > lo) && ({1'b0, d} < hi);
    endfunction

endpackage

>>> rtl/necir_front.sv
// Front end: configuration registers and per-symbol duration classification.
module necir_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [necir_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  necir_pkg::t_ticks                 i_cfg_data,
    input  logic                              i_push,
    input  necir_pkg::t_sym                   i_sym,
    input  logic                              i_cq_full,
    output logic                              o_cq_wr,
    output necir_pkg::t_cls                   o_cls
);

    necir_pkg::t_ticks r_tolerance, r_lead_mark, r_lead_space, r_repeat_mark;
    necir_pkg::t_ticks r_repeat_space, r_bit_mark, r_zero_space, r_one_space;
    logic              mark_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance    <= necir_pkg::RST_TOLERANCE;
            r_lead_mark    <= necir_pkg::RST_LEAD_MARK;
            r_lead_space   <= necir_pkg::RST_LEAD_SPACE;
            r_repeat_mark  <= necir_pkg::RST_REPEAT_MARK;
            r_repeat_space <= necir_pkg::RST_REPEAT_SPACE;
            r_bit_mark     <= necir_pkg::RST_BIT_MARK;
            r_zero_space   <= necir_pkg::RST_ZERO_SPACE;
            r_one_space    <= necir_pkg::RST_ONE_SPACE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                necir_pkg::CFG_TOLERANCE:    r_tolerance    <= i_cfg_data;
                necir_pkg::CFG_LEAD_MARK:    r_lead_mark    <= i_cfg_data;
                necir_pkg::CFG_LEAD_SPACE:   r_lead_space   <= i_cfg_data;
                necir_pkg::CFG_REPEAT_MARK:  r_repeat_mark  <= i_cfg_data;
                necir_pkg::CFG_REPEAT_SPACE: r_repeat_space <= i_cfg_data;
                necir_pkg::CFG_BIT_MARK:     r_bit_mark     <= i_cfg_data;
                necir_pkg::CFG_ZERO_SPACE:   r_zero_space   <= i_cfg_data;
                necir_pkg::CFG_ONE_SPACE:    r_one_space    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        mark_bit = necir_pkg::near_value(i_sym.mark_ticks, r_bit_mark, r_tolerance);
        o_cls.leader_ok =
            necir_pkg::near_value(i_sym.mark_ticks, r_lead_mark, r_tolerance) &&
            necir_pkg::near_value(i_sym.space_ticks, r_lead_space, r_tolerance);
        o_cls.repeat_ok =
            necir_pkg::near_value(i_sym.mark_ticks, r_repeat_mark, r_tolerance) &&
            necir_pkg::near_value(i_sym.space_ticks, r_repeat_space, r_tolerance);
        o_cls.bit_one  = mark_bit &&
            necir_pkg::near_value(i_sym.space_ticks, r_one_space, r_tolerance);
        o_cls.bit_zero = mark_bit &&
            necir_pkg::near_value(i_sym.space_ticks, r_zero_space, r_tolerance);
        o_cls.last     = i_sym.last;
    end

    assign o_cq_wr = i_push && !i_cq_full;

endmodule

>>> rtl/necir_cq.sv
// Short queue of classified symbols between the front end and the frame tracker.
module necir_cq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  necir_pkg::t_cls i_wdata,
    output logic            o_full,
    output logic            o_valid,
    output necir_pkg::t_cls o_rdata,
    input  logic            i_rd
);

    necir_pkg::t_cls                  r_mem [necir_pkg::CQ_DEPTH];
    logic [necir_pkg::CQ_PTR_W-1:0]   r_wp, r_rp;
    logic [necir_pkg::CQ_PTR_W:0]     r_cnt;
    logic                             do_rd;

    assign o_full  = (r_cnt == (necir_pkg::CQ_PTR_W+1)'(necir_pkg::CQ_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rdata = r_mem[r_rp];
    assign do_rd   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (necir_pkg::CQ_PTR_W+1)'(i_wr)
                           - (necir_pkg::CQ_PTR_W+1)'(do_rd);
        end
    end

endmodule

>>> rtl/necir_back.sv
// Back end: capture state, frame assembly and the result queue.
module necir_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cq_valid,
    input  necir_pkg::t_cls i_cls,
    output logic            o_cq_rd,
    output logic            o_empty,
    output necir_pkg::t_res o_res,
    input  logic            i_pop
);

    logic [necir_pkg::CNT_W-1:0]      r_count, n_count;
    logic [necir_pkg::WORD_W-1:0]     r_bits, n_bits;
    logic                             r_leader, n_leader;
    logic                             r_repeat, n_repeat;
    logic                             r_err, n_err;
    logic [necir_pkg::CNT_W-1:0]      r_bad, n_bad;

    necir_pkg::t_res                  r_oq [necir_pkg::OQ_DEPTH];
    logic [necir_pkg::OQ_PTR_W-1:0]   r_owp, r_orp;
    logic [necir_pkg::OQ_PTR_W:0]     r_ocnt;

    logic                             oq_full, res_wr, do_pop;
    logic [necir_pkg::BIT_IDX_W-1:0]  bit_idx;
    necir_pkg::t_res                  res;

    assign oq_full = (r_ocnt == (necir_pkg::OQ_PTR_W+1)'(necir_pkg::OQ_DEPTH));
    assign o_empty = (r_ocnt == '0);
    assign o_res   = r_oq[r_orp];
    assign do_pop  = i_pop && !o_empty;
    assign o_cq_rd = i_cq_valid && (!i_cls.last || !oq_full);
    assign res_wr  = o_cq_rd && i_cls.last;
    assign bit_idx = necir_pkg::BIT_IDX_W'(r_count - 1'b1);

    always_comb begin
        n_count  = r_count;
        n_bits   = r_bits;
        n_leader = r_leader;
        n_repeat = r_repeat;
        n_err    = r_err;
        n_bad    = r_bad;
        res.status     = necir_pkg::ST_BAD_LENGTH;
        res.frame_word = '0;
        res.bad_index  = '0;

        if (o_cq_rd) begin
            if (r_count == '0) begin
                n_leader = i_cls.leader_ok;
                n_repeat = i_cls.repeat_ok;
            end else if ((r_count <= necir_pkg::CNT_W'(necir_pkg::DATA_SYMBOLS)) && !r_err) begin
                priority if (i_cls.bit_one) begin
                    n_bits[bit_idx] = 1'b1;
                end else if (i_cls.bit_zero) begin
                    n_bits[bit_idx] = 1'b0;
                end else begin
                    n_err = 1'b1;
                    n_bad = r_count;
                end
            end
            if (r_count < necir_pkg::CNT_W'(necir_pkg::COUNT_LIMIT)) begin
                n_count = r_count + 1'b1;
            end

            if (n_count == necir_pkg::CNT_W'(necir_pkg::FRAME_SYMBOLS)) begin
                priority if (!n_leader) begin
                    res.status = necir_pkg::ST_BAD_LEADER;
                end else if (n_err) begin
                    res.status    = necir_pkg::ST_BAD_DATA;
                    res.bad_index = n_bad;
                end else begin
                    res.status     = necir_pkg::ST_FRAME_OK;
                    res.frame_word = n_bits;
                end
            end else if (n_count == necir_pkg::CNT_W'(necir_pkg::REPEAT_SYMBOLS)) begin
                res.status = n_repeat ? necir_pkg::ST_REPEAT : necir_pkg::ST_BAD_LENGTH;
            end

            if (i_cls.last) begin
                n_count  = '0;
                n_bits   = '0;
                n_leader = 1'b0;
                n_repeat = 1'b0;
                n_err    = 1'b0;
                n_bad    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_wr) begin
            r_oq[r_owp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_bits   <= '0;
            r_leader <= 1'b0;
            r_repeat <= 1'b0;
            r_err    <= 1'b0;
            r_bad    <= '0;
            r_owp    <= '0;
            r_orp    <= '0;
            r_ocnt   <= '0;
        end else begin
            r_count  <= n_count;
            r_bits   <= n_bits;
            r_leader <= n_leader;
            r_repeat <= n_repeat;
            r_err    <= n_err;
            r_bad    <= n_bad;
            if (res_wr) begin
                r_owp <= r_owp + 1'b1;
            end
            if (do_pop) begin
                r_orp <= r_orp + 1'b1;
            end
            r_ocnt <= r_ocnt + (necir_pkg::OQ_PTR_W+1)'(res_wr)
                             - (necir_pkg::OQ_PTR_W+1)'(do_pop);
        end
    end

endmodule

>>> rtl/nec_ir_frame_decoder.sv
// Top level of the NEC infrared frame decoder: front end, symbol queue and back end.
// Throughput: one symbol per cycle while the symbol queue is not full; the back end retires
// one queued symbol per cycle unless a last symbol finds the result queue full.
// The four-entry symbol queue and two-entry result queue let either side stall alone.
// Reset is synchronous and active low: registers return to their nominal values,
// both queues empty and the capture state clears.
module nec_ir_frame_decoder (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [necir_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  necir_pkg::t_ticks                 i_cfg_data,
    input  logic                              push,
    output logic                              full,
    input  necir_pkg::t_sym                   i_sym,
    output logic                              empty,
    input  logic                              pop,
    output necir_pkg::t_res                   o_res
);

    logic            cq_wr, cq_full, cq_valid, cq_rd;
    necir_pkg::t_cls cls_in, cls_out;

    necir_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_push    (push),
        .i_sym     (i_sym),
        .i_cq_full (cq_full),
        .o_cq_wr   (cq_wr),
        .o_cls     (cls_in)
    );

    necir_cq u_cq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (cq_wr),
        .i_wdata(cls_in),
        .o_full (cq_full),
        .o_valid(cq_valid),
        .o_rdata(cls_out),
        .i_rd   (cq_rd)
    );

    necir_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cq_valid(cq_valid),
        .i_cls     (cls_out),
        .o_cq_rd   (cq_rd),
        .o_empty   (empty),
        .o_res     (o_res),
        .i_pop     (pop)
    );

    assign full = cq_full;

    a_word_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_res.status != necir_pkg::ST_FRAME_OK)) |-> (o_res.frame_word == '0))
        else $error("frame word set on a result that is not a good frame");

    a_index_only_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_res.status != necir_pkg::ST_BAD_DATA)) |-> (o_res.bad_index == '0))
        else $error("bad index set on a result without a data error");

    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_res.status == necir_pkg::ST_BAD_DATA)) |->
        ((o_res.bad_index != '0) &&
         (o_res.bad_index <= necir_pkg::CNT_W'(necir_pkg::DATA_SYMBOLS))))
        else $error("bad index outside the data symbols");

    a_no_read_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cq_rd |-> cq_valid)
        else $error("symbol queue read while empty");

endmodule

>>> bench/tb_nec_ir_frame_decoder.sv
// Testbench for the NEC infrared frame decoder: directed and random captures checked field by field.
module tb_nec_ir_frame_decoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCRIPT_LEN  = 22;
    localparam int NUM_PHASES  = 9;
    localparam int PHASE_ITEMS = 150;
    localparam int SETTLE      = 12;

    typedef struct {
        necir_pkg::t_sym    sym;
        logic               typed;
        necir_pkg::t_status st;
    } t_row;

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_cfg_we   = 1'b0;
    logic [necir_pkg::CFG_IDX_W-1:0] i_cfg_idx  = necir_pkg::CFG_TOLERANCE;
    necir_pkg::t_ticks               i_cfg_data = '0;
    logic                            push       = 1'b0;
    logic                            full;
    necir_pkg::t_sym                 i_sym      = '0;
    logic                            empty;
    logic                            pop        = 1'b0;
    necir_pkg::t_res                 o_res;

    necir_pkg::t_ticks reg_val [8] = '{
        necir_pkg::RST_TOLERANCE, necir_pkg::RST_LEAD_MARK, necir_pkg::RST_LEAD_SPACE,
        necir_pkg::RST_REPEAT_MARK, necir_pkg::RST_REPEAT_SPACE, necir_pkg::RST_BIT_MARK,
        necir_pkg::RST_ZERO_SPACE, necir_pkg::RST_ONE_SPACE};
    necir_pkg::t_ticks cfg_next [8];

    int          cap_count = 0;
    logic [31:0] cap_bits  = '0;
    logic        lead_hit  = 1'b0;
    logic        rpt_hit   = 1'b0;
    logic        data_bad  = 1'b0;
    logic [5:0]  bad_sym   = '0;

    necir_pkg::t_res decoded_q [$];
    necir_pkg::t_res want_res;
    int   mismatch_count = 0;
    int   send_idle      = 0;
    int   recv_stall     = 0;
    int   sent_syms      = 0;
    int   odd_len [6]    = '{1, 3, 33, 35, 63, 70};

    t_row script [SCRIPT_LEN] = '{
        '{'{15'd0,     15'd0,     1'b1}, 1'b1, necir_pkg::ST_BAD_LENGTH},
        '{'{15'd32767, 15'd32767, 1'b1}, 1'b1, necir_pkg::ST_BAD_LENGTH},
        '{'{15'd9000,  15'd2250,  1'b0}, 1'b0, necir_pkg::ST_FRAME_OK},
        '{'{15'd0,     15'd0,     1'b1}, 1'b1, necir_pkg::ST_REPEAT},
        '{'{15'd8801,  15'd2051,  1'b0}, 1'b0, necir_pkg::ST_FRAME_OK},
        '{'{15'd32767, 15'd0,     1'b1}, 1'b1, necir_pkg::ST_REPEAT},
        '{'{15'd9199,  15'd2449,  1'b0}, 1'b0, necir_pkg::ST_FRAME_OK},
        '{'{15'd32767, 15'd32767, 1'b1}, 1'b1, necir_pkg::ST_REPEAT},
        '{'{15'd8800,  15'd2250,  1'b0}, 1'b0, necir_pkg::ST_FRAME_OK},
        '{'{15'd0,     15'd0,     1'b1}, 1'b1, necir_pkg::ST_BAD_LENGTH},
        '{'{15'd9000,  15'd2450,  1'b0}, 1'b0, necir_pkg::ST_FRAME_OK},
        '{'{15'd0,     15'd32767, 1'b1}, 1'b1, necir_pkg::ST_BAD_LENGTH},
        '{'{15'd9000,  15'd4500,  1'b0}, 1'b0, necir_pkg::ST_FRAME_OK},
        '{'{15'd560,   15'd1690,  1'b1}, 1'b1, necir_pkg::ST_BAD_LENGTH},
        '{'{15'd9000,  15'd2250,  1'b0}, 1'b0, necir_pkg::ST_FRAME_OK},
        '{'{15'd560,   15'd560,   1'b0}, 1'b0, necir_pkg::ST_FRAME_OK},
        '{'{15'd560,   15'd1690,  1'b1}, 1'b1, necir_pkg::ST_BAD_LENGTH},
        '{'{15'd0,     15'd32767, 1'b0}, 1'b0, necir_pkg::ST_FRAME_OK},
        '{'{15'd32767, 15'd0,     1'b0}, 1'b0, necir_pkg::ST_FRAME_OK},
        '{'{15'd9000,  15'd4500,  1'b1}, 1'b1, necir_pkg::ST_BAD_LENGTH},
        '{'{15'd16383, 15'd16384, 1'b1}, 1'b1, necir_pkg::ST_BAD_LENGTH},
        '{'{15'd21845, 15'd10922, 1'b1}, 1'b1, necir_pkg::ST_BAD_LENGTH}
    };

    nec_ir_frame_decoder u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .push       (push),
        .full       (full),
        .i_sym      (i_sym),
        .empty      (empty),
        .pop        (pop),
        .o_res      (o_res)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic near_nominal(necir_pkg::t_ticks d, necir_pkg::t_ticks nom);
        logic [31:0] hi;
        logic [31:0] lo;
        hi = 32'(nom) + 32'(reg_val[necir_pkg::CFG_TOLERANCE]);
        lo = 32'(nom) - 32'(reg_val[necir_pkg::CFG_TOLERANCE]);
        return (32'(d) < hi) && (32'(d) > lo);
    endfunction

    task automatic decode_symbol(input necir_pkg::t_sym s, output logic has_res,
                                 output necir_pkg::t_res r);
        int idx;
        idx = cap_count;
        r = '0;
        if (idx == 0) begin
            lead_hit = near_nominal(s.mark_ticks, reg_val[necir_pkg::CFG_LEAD_MARK])
                    && near_nominal(s.space_ticks, reg_val[necir_pkg::CFG_LEAD_SPACE]);
            rpt_hit  = near_nominal(s.mark_ticks, reg_val[necir_pkg::CFG_REPEAT_MARK])
                    && near_nominal(s.space_ticks, reg_val[necir_pkg::CFG_REPEAT_SPACE]);
        end else if (idx <= necir_pkg::DATA_SYMBOLS && !data_bad) begin
            if (near_nominal(s.mark_ticks, reg_val[necir_pkg::CFG_BIT_MARK])
                    && near_nominal(s.space_ticks, reg_val[necir_pkg::CFG_ONE_SPACE])) begin
                cap_bits[idx-1] = 1'b1;
            end else if (near_nominal(s.mark_ticks, reg_val[necir_pkg::CFG_BIT_MARK])
                    && near_nominal(s.space_ticks, reg_val[necir_pkg::CFG_ZERO_SPACE])) begin
                cap_bits[idx-1] = 1'b0;
            end else begin
                data_bad = 1'b1;
                bad_sym  = 6'(idx);
            end
        end
        if (cap_count < necir_pkg::COUNT_LIMIT) begin
            cap_count++;
        end
        has_res = s.last;
        if (s.last) begin
            if (cap_count == necir_pkg::FRAME_SYMBOLS) begin
                if (!lead_hit) begin
                    r.status = necir_pkg::ST_BAD_LEADER;
                end else if (data_bad) begin
                    r.status    = necir_pkg::ST_BAD_DATA;
                    r.bad_index = bad_sym;
                end else begin
                    r.status     = necir_pkg::ST_FRAME_OK;
                    r.frame_word = cap_bits;
                end
            end else if (cap_count == necir_pkg::REPEAT_SYMBOLS) begin
                r.status = rpt_hit ? necir_pkg::ST_REPEAT : necir_pkg::ST_BAD_LENGTH;
            end else begin
                r.status = necir_pkg::ST_BAD_LENGTH;
            end
            cap_count = 0;
            cap_bits  = '0;
            lead_hit  = 1'b0;
            rpt_hit   = 1'b0;
            data_bad  = 1'b0;
            bad_sym   = '0;
        end
    endtask

    task automatic send_symbol(input necir_pkg::t_sym s, input logic use_typed,
                               input necir_pkg::t_res typed);
        logic            has_res;
        necir_pkg::t_res r;
        while ($urandom_range(99) < send_idle) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push  <= 1'b1;
        i_sym <= s;
        do @(posedge i_clk); while (full);
        sent_syms++;
        decode_symbol(s, has_res, r);
        if (has_res) begin
            decoded_q.push_back(use_typed ? typed : r);
        end
    endtask

    // Near the tolerance edges the duration may land just inside or just outside the window.
    function automatic necir_pkg::t_ticks jitter(necir_pkg::t_ticks nom, logic edgy);
        int tol;
        int v;
        tol = reg_val[necir_pkg::CFG_TOLERANCE];
        if (edgy) begin
            case ($urandom_range(4))
                0: v = int'(nom) + tol;
                1: v = int'(nom) - tol;
                2: v = int'(nom) + tol - 1;
                3: v = int'(nom) - tol + 1;
                default: v = int'($urandom_range(32767));
            endcase
        end else if (tol > 1) begin
            v = int'(nom) + int'($urandom_range(2 * tol - 2)) - (tol - 1);
        end else begin
            v = int'(nom);
        end
        if (v < 0) v = 0;
        if (v > 32767) v = 32767;
        return necir_pkg::t_ticks'(v);
    endfunction

    task automatic send_capture(input int len, input logic as_repeat, input logic noisy,
                                input int bad_at);
        necir_pkg::t_sym   s;
        necir_pkg::t_ticks nm;
        necir_pkg::t_ticks ns;
        for (int i = 0; i < len; i++) begin
            if (noisy || i > necir_pkg::DATA_SYMBOLS) begin
                nm = necir_pkg::t_ticks'($urandom_range(32767));
                ns = necir_pkg::t_ticks'($urandom_range(32767));
            end else if (i == 0) begin
                nm = as_repeat ? reg_val[necir_pkg::CFG_REPEAT_MARK]
                               : reg_val[necir_pkg::CFG_LEAD_MARK];
                ns = as_repeat ? reg_val[necir_pkg::CFG_REPEAT_SPACE]
                               : reg_val[necir_pkg::CFG_LEAD_SPACE];
            end else begin
                nm = reg_val[necir_pkg::CFG_BIT_MARK];
                ns = $urandom_range(1) ? reg_val[necir_pkg::CFG_ONE_SPACE]
                                       : reg_val[necir_pkg::CFG_ZERO_SPACE];
            end
            if (!noisy && i <= necir_pkg::DATA_SYMBOLS) begin
                nm = jitter(nm, i == bad_at);
                ns = jitter(ns, i == bad_at);
            end
            s.mark_ticks  = nm;
            s.space_ticks = ns;
            s.last        = (i == len - 1);
            send_symbol(s, 1'b0, '0);
        end
    endtask

    task automatic wait_idle(input int settle);
        push <= 1'b0;
        @(posedge i_clk);
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic load_registers();
        for (int k = 0; k < 8; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= necir_pkg::CFG_IDX_W'(k);
            i_cfg_data <= cfg_next[k];
            reg_val[k] = cfg_next[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic flag_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch in %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (decoded_q.size() == 0) begin
                flag_mismatch("unexpected transfer", 32'(o_res.status), '0);
            end else begin
                want_res = decoded_q.pop_front();
                if (o_res.status !== want_res.status)
                    flag_mismatch("status", 32'(o_res.status), 32'(want_res.status));
                if (o_res.frame_word !== want_res.frame_word)
                    flag_mismatch("frame_word", o_res.frame_word, want_res.frame_word);
                if (o_res.bad_index !== want_res.bad_index)
                    flag_mismatch("bad_index", 32'(o_res.bad_index), 32'(want_res.bad_index));
            end
        end
        pop <= ($urandom_range(99) >= recv_stall);
    end

    initial begin
        int pick;
        int phase_start;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[n]) begin
            send_symbol(script[n].sym, script[n].typed,
                        necir_pkg::t_res'{script[n].st, 32'd0, 6'd0});
        end
        send_capture(necir_pkg::FRAME_SYMBOLS, 1'b0, 1'b0, -1);
        send_capture(necir_pkg::FRAME_SYMBOLS, 1'b0, 1'b0, 7);
        send_capture(necir_pkg::FRAME_SYMBOLS, 1'b0, 1'b0, 0);
        send_capture(70, 1'b0, 1'b0, -1);
        send_capture(35, 1'b0, 1'b0, -1);

        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_idle(SETTLE);
            cfg_next = '{necir_pkg::RST_TOLERANCE, necir_pkg::RST_LEAD_MARK,
                         necir_pkg::RST_LEAD_SPACE, necir_pkg::RST_REPEAT_MARK,
                         necir_pkg::RST_REPEAT_SPACE, necir_pkg::RST_BIT_MARK,
                         necir_pkg::RST_ZERO_SPACE, necir_pkg::RST_ONE_SPACE};
            case (p)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 73; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 73; end
                3: begin send_idle = 37; recv_stall = 37; end
                4: begin
                    send_idle = 37; recv_stall = 37;
                    cfg_next[necir_pkg::CFG_TOLERANCE] = '0;
                end
                5: begin
                    send_idle = 0; recv_stall = 0;
                    foreach (cfg_next[k]) cfg_next[k] = 15'd32767;
                end
                6: begin
                    send_idle = 73; recv_stall = 0;
                    cfg_next = '{15'd500, 15'd12000, 15'd6000, 15'd12000,
                                 15'd3000, 15'd400, 15'd800, 15'd2400};
                end
                7: begin
                    send_idle = 0; recv_stall = 73;
                    cfg_next[necir_pkg::CFG_TOLERANCE]  = 15'd400;
                    cfg_next[necir_pkg::CFG_ZERO_SPACE] = 15'd1000;
                    cfg_next[necir_pkg::CFG_ONE_SPACE]  = 15'd1000;
                end
                default: begin
                    send_idle = 37; recv_stall = 37;
                    cfg_next[necir_pkg::CFG_TOLERANCE] =
                        necir_pkg::t_ticks'($urandom_range(1500));
                    for (int k = 1; k < 8; k++) begin
                        case ($urandom_range(7))
                            0: cfg_next[k] = '0;
                            1: cfg_next[k] = 15'd32767;
                            default: cfg_next[k] = necir_pkg::t_ticks'($urandom_range(32767));
                        endcase
                    end
                end
            endcase
            load_registers();

            phase_start = sent_syms;
            while (sent_syms - phase_start < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 45)
                    send_capture(necir_pkg::FRAME_SYMBOLS, 1'b0, 1'b0, -1);
                else if (pick < 60)
                    send_capture(necir_pkg::FRAME_SYMBOLS, 1'b0, 1'b0,
                                 $urandom_range(1, necir_pkg::DATA_SYMBOLS));
                else if (pick < 68)
                    send_capture(necir_pkg::FRAME_SYMBOLS, 1'b0, 1'b0, 0);
                else if (pick < 78)
                    send_capture(necir_pkg::REPEAT_SYMBOLS, 1'b1, 1'b0, -1);
                else if (pick < 84)
                    send_capture(necir_pkg::REPEAT_SYMBOLS, 1'b1, 1'b0, 0);
                else if (pick < 92)
                    send_capture(odd_len[$urandom_range(5)], 1'b0, 1'b0, -1);
                else
                    send_capture($urandom_range(1, 70), 1'b0, 1'b1, -1);
                if ($urandom_range(11) == 0) begin
                    wait_idle(0);
                end
            end
        end

        wait_idle(SETTLE);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
